/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; they compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/arrcs_pkg.sv */
// Constants, codes and scale-factor functions for the round-robin calibrated ADC scaler.
package arrcs_pkg;

   // Board constants
   localparam longint REF_MILLIVOLTS        = 2500;
   localparam longint DIVIDER_INPUT_OHMS    = 100000;
   localparam longint DIVIDER_FEEDBACK_OHMS = 10000;
   localparam longint SENSE_AMP_GAIN        = 50;
   localparam longint SHUNT_MILLIOHMS       = 10;

   localparam longint PPM_ONE   = 1000000;
   localparam longint CODE_SPAN = 32768;
   localparam longint MILLI     = 1000;

   // Field widths
   localparam int CODE_W  = 16;
   localparam int GAIN_W  = 21;
   localparam int CHAN_W  = 3;
   localparam int OUT_W   = 24;
   localparam int INDEX_W = 4;
   localparam int NUM_CH  = 5;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(PPM_ONE);

   // Channel codes
   localparam logic [CHAN_W-1:0] CH_VOUT = 3'd0;
   localparam logic [CHAN_W-1:0] CH_IOUT = 3'd1;
   localparam logic [CHAN_W-1:0] CH_VIN  = 3'd2;
   localparam logic [CHAN_W-1:0] CH_CC   = 3'd3;
   localparam logic [CHAN_W-1:0] CH_CV   = 3'd4;

   // Register indexes
   localparam logic [INDEX_W-1:0] REG_VOUT_ZERO   = 4'd0;
   localparam logic [INDEX_W-1:0] REG_IOUT_ZERO   = 4'd1;
   localparam logic [INDEX_W-1:0] REG_VIN_ZERO    = 4'd2;
   localparam logic [INDEX_W-1:0] REG_CC_ZERO     = 4'd3;
   localparam logic [INDEX_W-1:0] REG_CV_ZERO     = 4'd4;
   localparam logic [INDEX_W-1:0] REG_SHARED_GAIN = 4'd5;
   localparam logic [INDEX_W-1:0] REG_CC_GAIN     = 4'd6;
   localparam logic [INDEX_W-1:0] REG_CV_GAIN     = 4'd7;

   // Scale classes
   localparam logic [1:0] CLS_VOLT = 2'd0;
   localparam logic [1:0] CLS_CURR = 2'd1;
   localparam logic [1:0] CLS_RB   = 2'd2;

   // Scale factors: value = (cal * MUL + DEN/2) / DEN
   localparam longint MUL_VOLT = REF_MILLIVOLTS * DIVIDER_INPUT_OHMS;
   localparam longint DEN_VOLT = CODE_SPAN * DIVIDER_FEEDBACK_OHMS;
   localparam longint MUL_CURR = REF_MILLIVOLTS * MILLI;
   localparam longint DEN_CURR = CODE_SPAN * SENSE_AMP_GAIN * SHUNT_MILLIOHMS;
   localparam longint MUL_RB   = REF_MILLIVOLTS;
   localparam longint DEN_RB   = CODE_SPAN;

   // Saturation: the rounded quotient exceeds the output range when
   // cal * MUL >= DEN * 2^OUT_W - DEN/2
   localparam longint THR_VOLT = (DEN_VOLT << OUT_W) - DEN_VOLT / 2;
   localparam longint THR_CURR = (DEN_CURR << OUT_W) - DEN_CURR / 2;
   localparam longint THR_RB   = (DEN_RB << OUT_W) - DEN_RB / 2;

   function automatic longint max3(input longint a, input longint b, input longint c);
      longint m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   localparam longint MUL_MAX = max3(MUL_VOLT, MUL_CURR, MUL_RB);
   localparam longint DEN_MAX = max3(DEN_VOLT, DEN_CURR, DEN_RB);
   localparam longint THR_MAX = max3(THR_VOLT, THR_CURR, THR_RB);

   localparam int MUL_W  = $clog2(MUL_MAX + 1);
   localparam int DEN_W  = $clog2(DEN_MAX + 1);
   localparam int REM2_W = DEN_W + 1;
   // Accumulator holds cal * MUL below the threshold plus one Horner step
   localparam int ACC_W  = $clog2(2 * THR_MAX + MUL_MAX + 1);
   // Gain division dividend: diff * 1e6 + gain / 2
   localparam int NUM_W  = $clog2((longint'(1) << CODE_W) * PPM_ONE + (longint'(1) << GAIN_W));
   localparam int CNT_W  = $clog2((NUM_W > OUT_W) ? NUM_W : OUT_W);

   function automatic logic [MUL_W-1:0] scale_mul(input logic [1:0] cls);
      case (cls)
         CLS_VOLT: return MUL_W'(MUL_VOLT);
         CLS_CURR: return MUL_W'(MUL_CURR);
         default:  return MUL_W'(MUL_RB);
      endcase
   endfunction

   function automatic logic [DEN_W-1:0] scale_den(input logic [1:0] cls);
      case (cls)
         CLS_VOLT: return DEN_W'(DEN_VOLT);
         CLS_CURR: return DEN_W'(DEN_CURR);
         default:  return DEN_W'(DEN_RB);
      endcase
   endfunction

   function automatic logic [ACC_W-1:0] scale_thr(input logic [1:0] cls);
      case (cls)
         CLS_VOLT: return ACC_W'(THR_VOLT);
         CLS_CURR: return ACC_W'(THR_CURR);
         default:  return ACC_W'(THR_RB);
      endcase
   endfunction

endpackage

/* rtl/adc_round_robin_calibrated_scaler.sv */
// Round-robin calibrated ADC scaler: zero and gain correction, unit scaling, channel sequencing.
//
// Takes one signed ADC code per transfer while stepping through five channels (vout, iout,
// vin, CC readback, CV readback); the first code after each channel change is dropped. A
// kept code has its channel zero subtracted, is multiplied by 1e6 and divided by the ppm
// gain with rounding, then scaled to mV or mA with rounding and clamped to 24 bits.
// A dropped code leaves the block idle and a code at or below its zero goes straight to
// the output stage; any other kept code runs a bit-serial restoring divider for the gain
// (36 steps, whose quotient bits feed a shift-add multiplier for the unit scale) followed
// by a 24-step bit-serial divider for the unit conversion. A kept code whose value clamps
// skips the second divider. The next code may be taken while a result waits on the output
// register; a finished result that finds the output register still occupied is held in
// the block, which delays the next transfer until it moves out.
`include "assert_macros.svh"

module adc_round_robin_calibrated_scaler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [arrcs_pkg::CODE_W-1:0]  req_raw_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [arrcs_pkg::CHAN_W-1:0]  rsp_channel,
   output logic signed [arrcs_pkg::CODE_W-1:0]  rsp_raw_echo,
   output logic        [arrcs_pkg::OUT_W-1:0]   rsp_scaled_value,
   output logic        [arrcs_pkg::CHAN_W-1:0]  rsp_next_channel,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [arrcs_pkg::INDEX_W-1:0] csr_index,
   input  logic        [arrcs_pkg::GAIN_W-1:0]  csr_wdata
);
   import arrcs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_MID  = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // Control and configuration state
   logic [2:0]        state_ff, state_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic              discard_ff, discard_in;
   logic [CODE_W-1:0] zero_ff [NUM_CH];
   logic [CODE_W-1:0] zero_in [NUM_CH];
   logic [GAIN_W-1:0] shared_gain_ff, shared_gain_in;
   logic [GAIN_W-1:0] cc_gain_ff, cc_gain_in;
   logic [GAIN_W-1:0] cv_gain_ff, cv_gain_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item payload and datapath
   logic [CHAN_W-1:0] ch_ff, ch_in;
   logic [CHAN_W-1:0] next_ff, next_in;
   logic [CODE_W-1:0] raw_ff, raw_in;
   logic [1:0]        cls_ff, cls_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [CODE_W-1:0] diff_ff, diff_in;
   logic [NUM_W-1:0]  num_sr_ff, num_sr_in;
   logic [GAIN_W-1:0] rem1_ff, rem1_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              sat_ff, sat_in;
   logic [REM2_W-1:0] rem2_ff, rem2_in;
   logic [OUT_W-1:0]  quo_sr_ff, quo_sr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CHAN_W-1:0] rsp_channel_ff, rsp_channel_in;
   logic [CODE_W-1:0] rsp_raw_ff, rsp_raw_in;
   logic [OUT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [CHAN_W-1:0] rsp_next_ff, rsp_next_in;

   // Combinational helpers
   logic [CHAN_W-1:0]  ch_eff;
   logic [CHAN_W-1:0]  ch_next;
   logic [GAIN_W-1:0]  gain_sel;
   logic [1:0]         cls_sel;
   logic signed [CODE_W:0] diff_s;
   logic [GAIN_W:0]    t1;
   logic               ge1;
   logic [GAIN_W:0]    sub1;
   logic [ACC_W-1:0]   acc_step;
   logic               sat_hit;
   logic [ACC_W-1:0]   div_sum;
   logic [REM2_W-1:0]  t2;
   logic               ge2;
   logic [DEN_W-1:0]   den;
   logic               in_xfer;
   logic               cfg_xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign in_xfer   = req_valid && req_ready;
   assign cfg_xfer  = csr_valid && csr_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_raw_echo     = rsp_raw_ff;
   assign rsp_scaled_value = rsp_value_ff;
   assign rsp_next_channel = rsp_next_ff;

   // Select channel, class, gain and zero for the incoming code
   always_comb begin
      ch_eff  = (chan_ff > CH_CV) ? CH_CV : chan_ff;
      ch_next = (ch_eff == CH_CV) ? CH_VOUT : ch_eff + CHAN_W'(1);
      case (ch_eff) inside
         CH_VOUT, CH_VIN: cls_sel = CLS_VOLT;
         CH_IOUT:         cls_sel = CLS_CURR;
         default:         cls_sel = CLS_RB;
      endcase
      case (ch_eff) inside
         CH_VOUT, CH_IOUT, CH_VIN: gain_sel = shared_gain_ff;
         CH_CC:                    gain_sel = cc_gain_ff;
         default:                  gain_sel = cv_gain_ff;
      endcase
      if (gain_sel == '0) begin
         gain_sel = GAIN_W'(1);
      end
      diff_s = $signed({req_raw_code[CODE_W-1], req_raw_code})
             - $signed({zero_ff[ch_eff][CODE_W-1], zero_ff[ch_eff]});
   end

   // Gain divider step, whose quotient bits feed the shift-add scale multiplier, and scale divider step
   always_comb begin
      t1       = {rem1_ff, num_sr_ff[NUM_W-1]};
      ge1      = (t1 >= {1'b0, gain_ff});
      sub1     = t1 - {1'b0, gain_ff};
      acc_step = {acc_ff[ACC_W-2:0], 1'b0} + (ge1 ? ACC_W'(scale_mul(cls_ff)) : '0);
      sat_hit  = (acc_step >= scale_thr(cls_ff));
      div_sum  = acc_ff + ACC_W'(scale_den(cls_ff) >> 1);
      den      = scale_den(cls_ff);
      t2       = {rem2_ff[REM2_W-2:0], quo_sr_ff[OUT_W-1]};
      ge2      = (t2 >= REM2_W'(den));
   end

   // Configuration writes
   always_comb begin
      zero_in        = zero_ff;
      shared_gain_in = shared_gain_ff;
      cc_gain_in     = cc_gain_ff;
      cv_gain_in     = cv_gain_ff;
      if (cfg_xfer) begin
         unique case (csr_index)
            REG_VOUT_ZERO:   zero_in[CH_VOUT] = csr_wdata[CODE_W-1:0];
            REG_IOUT_ZERO:   zero_in[CH_IOUT] = csr_wdata[CODE_W-1:0];
            REG_VIN_ZERO:    zero_in[CH_VIN]  = csr_wdata[CODE_W-1:0];
            REG_CC_ZERO:     zero_in[CH_CC]   = csr_wdata[CODE_W-1:0];
            REG_CV_ZERO:     zero_in[CH_CV]   = csr_wdata[CODE_W-1:0];
            REG_SHARED_GAIN: shared_gain_in   = csr_wdata;
            REG_CC_GAIN:     cc_gain_in       = csr_wdata;
            REG_CV_GAIN:     cv_gain_in       = csr_wdata;
            default:         ;
         endcase
      end
   end

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      discard_in   = discard_ff;
      rsp_valid_in = rsp_valid_ff;
      ch_in        = ch_ff;
      next_in      = next_ff;
      raw_in       = raw_ff;
      cls_in       = cls_ff;
      gain_in      = gain_ff;
      diff_in      = diff_ff;
      num_sr_in    = num_sr_ff;
      rem1_in      = rem1_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      rem2_in      = rem2_ff;
      quo_sr_in    = quo_sr_ff;
      cnt_in       = cnt_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_raw_in     = rsp_raw_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_next_in    = rsp_next_ff;

      // Drop the output once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               if (discard_ff) begin
                  discard_in = 1'b0;
               end else begin
                  ch_in      = ch_eff;
                  next_in    = ch_next;
                  raw_in     = req_raw_code;
                  cls_in     = cls_sel;
                  gain_in    = gain_sel;
                  diff_in    = diff_s[CODE_W-1:0];
                  chan_in    = ch_next;
                  discard_in = 1'b1;
                  if (diff_s > 0) begin
                     state_in = ST_PREP;
                  end else begin
                     quo_sr_in = '0;
                     state_in  = ST_DONE;
                  end
               end
            end
         end
         ST_PREP: begin
            num_sr_in = NUM_W'(diff_ff) * NUM_W'(PPM_ONE) + NUM_W'(gain_ff >> 1);
            rem1_in   = '0;
            acc_in    = '0;
            sat_in    = 1'b0;
            cnt_in    = CNT_W'(NUM_W - 1);
            state_in  = ST_DIV1;
         end
         ST_DIV1: begin
            num_sr_in = {num_sr_ff[NUM_W-2:0], 1'b0};
            rem1_in   = ge1 ? sub1[GAIN_W-1:0] : t1[GAIN_W-1:0];
            // Hold the accumulator once it has crossed the clamp threshold
            if (!sat_ff) begin
               if (sat_hit) begin
                  sat_in = 1'b1;
               end else begin
                  acc_in = acc_step;
               end
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            if (sat_ff) begin
               quo_sr_in = '1;
               state_in  = ST_DONE;
            end else begin
               rem2_in   = REM2_W'(div_sum >> OUT_W);
               quo_sr_in = div_sum[OUT_W-1:0];
               cnt_in    = CNT_W'(OUT_W - 1);
               state_in  = ST_DIV2;
            end
         end
         ST_DIV2: begin
            rem2_in   = ge2 ? (t2 - REM2_W'(den)) : t2;
            quo_sr_in = {quo_sr_ff[OUT_W-2:0], ge2};
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the output register when it is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = ch_ff;
               rsp_raw_in     = raw_ff;
               rsp_value_in   = quo_sr_ff;
               rsp_next_in    = next_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         chan_ff        <= CH_VOUT;
         discard_ff     <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         shared_gain_ff <= GAIN_RESET;
         cc_gain_ff     <= GAIN_RESET;
         cv_gain_ff     <= GAIN_RESET;
         sat_ff         <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            zero_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         chan_ff        <= chan_in;
         discard_ff     <= discard_in;
         rsp_valid_ff   <= rsp_valid_in;
         shared_gain_ff <= shared_gain_in;
         cc_gain_ff     <= cc_gain_in;
         cv_gain_ff     <= cv_gain_in;
         sat_ff         <= sat_in;
         zero_ff        <= zero_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ch_ff          <= ch_in;
      next_ff        <= next_in;
      raw_ff         <= raw_in;
      cls_ff         <= cls_in;
      gain_ff        <= gain_in;
      diff_ff        <= diff_in;
      num_sr_ff      <= num_sr_in;
      rem1_ff        <= rem1_in;
      acc_ff         <= acc_in;
      rem2_ff        <= rem2_in;
      quo_sr_ff      <= quo_sr_in;
      cnt_ff         <= cnt_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_raw_ff     <= rsp_raw_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_next_ff    <= rsp_next_in;
   end

   // Checks
   `ASSERT_ALWAYS(a_chan_range, clock, reset, chan_ff <= CH_CV, "channel pointer out of range")
   `ASSERT_NEXT(a_kept_arms_discard, clock, reset, in_xfer && !discard_ff,
                discard_ff && state_ff != ST_IDLE, "kept transfer did not arm discard")
   `ASSERT_IMPLY(a_next_follows, clock, reset, rsp_valid_ff,
                 rsp_next_ff == ((rsp_channel_ff == CH_CV) ? CH_VOUT
                                 : rsp_channel_ff + CHAN_W'(1)),
                 "next channel mismatch")
   `ASSERT_IMPLY(a_no_div_when_sat, clock, reset, state_ff == ST_DIV2, !sat_ff,
                 "scale divider run on clamped value")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the round-robin calibrated ADC scaler.
module tb;
   import arrcs_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 5;
   localparam int NUM_REGS       = 8;
   localparam int PHASE_ITEMS    = 195;
   localparam int DRAIN_CYCLES   = 100;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam int JUNK_W         = GAIN_W - CODE_W;

   // Board scale factors: reading = (cal * MUL + DEN / 2) / DEN
   localparam longint PPM_UNITY = 1000000;
   localparam longint VOLT_MUL  = 64'd2500 * 64'd100000;
   localparam longint VOLT_DEN  = 64'd32768 * 64'd10000;
   localparam longint CURR_MUL  = 64'd2500 * 64'd1000;
   localparam longint CURR_DEN  = 64'd32768 * 64'd50 * 64'd10;
   localparam longint RB_MUL    = 64'd2500;
   localparam longint RB_DEN    = 64'd32768;

   localparam logic [OUT_W-1:0]  READING_MAX   = '1;
   localparam logic [GAIN_W-1:0] ZERO_MASK     = {{JUNK_W{1'b0}}, {CODE_W{1'b1}}};
   localparam logic [GAIN_W-1:0] GAIN_LOW_PPM  = GAIN_W'(500000);
   localparam logic [GAIN_W-1:0] GAIN_HIGH_PPM = GAIN_W'(2000000);

   typedef struct {
      logic        [CHAN_W-1:0] channel;
      logic signed [CODE_W-1:0] raw_echo;
      logic        [OUT_W-1:0]  scaled_value;
      logic        [CHAN_W-1:0] next_channel;
   } reading_type;

   typedef enum {
      SET_DEFAULT, SET_RANDOM, SET_LOW, SET_HIGH, SET_TINY_GAIN, SET_FULL_GAIN
   } setting_type;

   localparam setting_type PHASE_PLAN [9] = '{
      SET_RANDOM, SET_LOW, SET_TINY_GAIN, SET_HIGH, SET_RANDOM,
      SET_FULL_GAIN, SET_TINY_GAIN, SET_RANDOM, SET_DEFAULT
   };

   // Kept codes of the opening sequence, each preceded by a dropped code
   localparam logic [CODE_W-1:0] OPENING_CODES [12] = '{
      16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000,
      16'hC000, 16'h7FFF, 16'h0064, 16'h7FFF, 16'h8001, 16'h0002
   };

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic signed [CODE_W-1:0] req_raw_code     = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic        [CHAN_W-1:0] rsp_channel;
   logic signed [CODE_W-1:0] rsp_raw_echo;
   logic        [OUT_W-1:0]  rsp_scaled_value;
   logic        [CHAN_W-1:0] rsp_next_channel;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   logic       [INDEX_W-1:0] csr_index        = '0;
   logic        [GAIN_W-1:0] csr_wdata        = '0;

   // Register mirror and sequencer state
   logic [GAIN_W-1:0] cfg_regs [NUM_REGS];
   logic [CHAN_W-1:0] mux_channel;
   logic              drop_pending;

   logic [CODE_W-1:0] pending_codes [$];
   reading_type       expected_readings [$];
   logic              req_done       = 1'b0;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                mismatch_count = 0;

   adc_round_robin_calibrated_scaler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_code     (req_raw_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel      (rsp_channel),
      .rsp_raw_echo     (rsp_raw_echo),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_next_channel (rsp_next_channel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Calibrate one code and convert it to mV or mA for the given channel
   function automatic logic [OUT_W-1:0] reading_in_units(input logic [CHAN_W-1:0] ch,
                                                         input logic [CODE_W-1:0] raw);
      longint       zero_code;
      longint       gain;
      longint       mul;
      longint       den;
      longint       num;
      longint       cal;
      logic [127:0] prod;
      logic [127:0] quot;
      case (ch) inside
         CH_VOUT, CH_VIN: begin
            gain = cfg_regs[REG_SHARED_GAIN];
            mul  = VOLT_MUL;
            den  = VOLT_DEN;
         end
         CH_IOUT: begin
            gain = cfg_regs[REG_SHARED_GAIN];
            mul  = CURR_MUL;
            den  = CURR_DEN;
         end
         CH_CC: begin
            gain = cfg_regs[REG_CC_GAIN];
            mul  = RB_MUL;
            den  = RB_DEN;
         end
         default: begin
            gain = cfg_regs[REG_CV_GAIN];
            mul  = RB_MUL;
            den  = RB_DEN;
         end
      endcase
      // Zero register index matches the channel code
      zero_code = $signed(cfg_regs[ch][CODE_W-1:0]);
      if (gain == 0)
         gain = 1;
      num = ($signed(raw) - zero_code) * PPM_UNITY;
      num = num + ((num >= 0) ? gain / 2 : -(gain / 2));
      cal = num / gain;
      if (cal <= 0)
         return '0;
      prod = 128'(cal) * 128'(mul) + 128'(den / 2);
      quot = prod / 128'(den);
      return (quot > READING_MAX) ? READING_MAX : quot[OUT_W-1:0];
   endfunction

   // Mix of full-range codes, codes near a zero register, and extremes
   function automatic logic [CODE_W-1:0] random_code();
      int pick;
      int base;
      pick = $urandom_range(99);
      if (pick < 45)
         return CODE_W'($urandom);
      if (pick < 80) begin
         base = $signed(cfg_regs[$urandom_range(NUM_CH - 1)][CODE_W-1:0]);
         return CODE_W'(base + int'($urandom_range(64)) - 32);
      end
      case ($urandom_range(4))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Present one register write and hold it until the transfer
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx < NUM_REGS)
         cfg_regs[idx] = (idx < REG_SHARED_GAIN) ? (data & ZERO_MASK) : data;
   endtask

   // Write every register for one setting, plus one write to an unused index
   task automatic apply_settings(input setting_type kind);
      logic [GAIN_W-1:0] word;
      for (int i = 0; i < NUM_CH; i++) begin
         case (kind)
            SET_DEFAULT: word = '0;
            SET_LOW:     word = {JUNK_W'($urandom), 16'h8000};
            SET_HIGH:    word = {JUNK_W'($urandom), 16'h7FFF};
            default: begin
               if ($urandom_range(1))
                  word = GAIN_W'($urandom);
               else
                  word = {JUNK_W'($urandom), CODE_W'(int'($urandom_range(4000)) - 2000)};
            end
         endcase
         write_reg(INDEX_W'(REG_VOUT_ZERO + i), word);
      end
      write_reg(INDEX_W'($urandom_range(2 ** INDEX_W - 1, NUM_REGS)), GAIN_W'($urandom));
      for (int j = 0; j < 3; j++) begin
         case (kind)
            SET_DEFAULT:   word = GAIN_RESET;
            SET_LOW:       word = GAIN_LOW_PPM;
            SET_HIGH:      word = GAIN_HIGH_PPM;
            SET_FULL_GAIN: word = '1;
            SET_TINY_GAIN: begin
               case ($urandom_range(2))
                  0:       word = '0;
                  1:       word = GAIN_W'(1);
                  default: word = GAIN_W'($urandom_range(4000, 2));
               endcase
            end
            default:       word = GAIN_W'($urandom_range(GAIN_HIGH_PPM, GAIN_LOW_PPM));
         endcase
         write_reg(INDEX_W'(REG_SHARED_GAIN + j), word);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold until every code is taken and every reading is back, then let the block settle
   task automatic wait_quiet();
      while (pending_codes.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Driver: present the next code, or idle, once the current one has transferred
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         req_done = 1'b0;
         if (pending_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_raw_code <= pending_codes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict the reading for each transferred code
   always @(posedge clock) begin : predict_conversion
      reading_type next_reading;
      if (reset) begin
         mux_channel  = CH_VOUT;
         drop_pending = 1'b1;
      end else if (req_valid && req_ready) begin
         req_done = 1'b1;
         if (drop_pending) begin
            drop_pending = 1'b0;
         end else begin
            next_reading.channel      = mux_channel;
            next_reading.raw_echo     = req_raw_code;
            next_reading.scaled_value = reading_in_units(mux_channel, req_raw_code);
            next_reading.next_channel = (mux_channel == CH_CV) ? CH_VOUT
                                        : mux_channel + CHAN_W'(1);
            mux_channel  = next_reading.next_channel;
            drop_pending = 1'b1;
            expected_readings.push_back(next_reading);
         end
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: compare each transferred reading with the oldest prediction
   always @(posedge clock) begin : reading_monitor
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected reading: channel %0d, value %0d", rsp_channel,
                   rsp_scaled_value);
            mismatch_count++;
         end else begin
            want = expected_readings.pop_front();
            check_field("channel", want.channel, rsp_channel);
            check_field("raw_echo", want.raw_echo, rsp_raw_echo);
            check_field("scaled_value", want.scaled_value, rsp_scaled_value);
            check_field("next_channel", want.next_channel, rsp_next_channel);
         end
      end
   end

   // Stimulus: opening sequence on reset values, then one random phase per setting
   initial begin
      for (int i = 0; i < NUM_REGS; i++)
         cfg_regs[i] = (i < REG_SHARED_GAIN) ? '0 : GAIN_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_CODES[k]) begin
         pending_codes.push_back(CODE_W'($urandom));
         pending_codes.push_back(OPENING_CODES[k]);
      end
      wait_quiet();

      foreach (PHASE_PLAN[p]) begin
         apply_settings(PHASE_PLAN[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         repeat (PHASE_ITEMS) pending_codes.push_back(random_code());
         wait_quiet();
      end

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
      $display("status: fail");
      $finish;
   end

endmodule
